// ===== rtl/gkc_pkg.sv =====
// Package: shared constants, types and state encoding for the k-center ordering block
package gkc_pkg;
    localparam int MAX_POINTS  = 64;
    localparam int MAX_DIMS    = 8;
    localparam int COORD_BITS  = 16;
    localparam int STORE_DEPTH = 512;
    localparam int ADDR_BITS   = 9;
    localparam int PT_BITS     = 6;
    localparam int NP_BITS     = 7;
    localparam int ND_BITS     = 4;
    localparam int DIM_BITS    = 3;
    localparam int DIST_BITS   = 36;
    localparam int RSQ_BITS    = 35;
    localparam int ROOT_BITS   = 18;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int SQ_BITS     = 2 * DIFF_BITS;

    localparam logic CFG_NUM_POINTS = 1'b0;
    localparam logic CFG_NUM_DIMS   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS_INIT,
        S_PT_START,
        S_RD,
        S_DIFF,
        S_SQ,
        S_ACC,
        S_UPD
    } state_t;

    typedef enum logic [1:0] {
        F_NONE,
        F_SEL,
        F_SQRT
    } fin_t;
endpackage

// ===== rtl/gkc_coord_mem.sv =====
// Coordinate store: one write port, two registered read ports
module gkc_coord_mem (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [gkc_pkg::ADDR_BITS-1:0]      wr_addr,
    input  logic [gkc_pkg::COORD_BITS-1:0]     wr_data,
    input  logic                               rd_en,
    input  logic [gkc_pkg::ADDR_BITS-1:0]      rd_addr_a,
    input  logic [gkc_pkg::ADDR_BITS-1:0]      rd_addr_b,
    output logic [gkc_pkg::COORD_BITS-1:0]     rd_data_a,
    output logic [gkc_pkg::COORD_BITS-1:0]     rd_data_b
);
    logic [gkc_pkg::COORD_BITS-1:0] mem [gkc_pkg::STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end
endmodule

// ===== rtl/gkc_dist_mem.sv =====
// Nearest-center distance store: one write port, one registered read port
module gkc_dist_mem (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [gkc_pkg::PT_BITS-1:0]        wr_addr,
    input  logic [gkc_pkg::DIST_BITS-1:0]      wr_data,
    input  logic                               rd_en,
    input  logic [gkc_pkg::PT_BITS-1:0]        rd_addr,
    output logic [gkc_pkg::DIST_BITS-1:0]      rd_data
);
    logic [gkc_pkg::DIST_BITS-1:0] mem [gkc_pkg::MAX_POINTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ===== rtl/gkc_sqrt.sv =====
// Floor square root, two radicand bits per cycle
module gkc_sqrt (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [gkc_pkg::RSQ_BITS-1:0]       value,
    output logic                               done,
    output logic [gkc_pkg::ROOT_BITS-1:0]      root
);
    localparam int RB = gkc_pkg::ROOT_BITS;

    logic [2*RB-1:0] x_reg;
    logic [RB+1:0]   rem_reg, rem_sh, trial, rem_next;
    logic [RB-1:0]   root_reg, root_next;
    logic [4:0]      cnt_reg;
    logic            run_reg, done_reg, ge;

    always_comb
    begin
        rem_sh    = {rem_reg[RB-1:0], x_reg[2*RB-1:2*RB-2]};
        trial     = {root_reg, 2'b01};
        ge        = rem_sh >= trial;
        rem_next  = ge ? rem_sh - trial : rem_sh;
        root_next = {root_reg[RB-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(RB - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= {{(2*RB-gkc_pkg::RSQ_BITS){1'b0}}, value};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            x_reg    <= {x_reg[2*RB-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// ===== rtl/greedy_k_center_ordering.sv =====
// Top level: greedy k-center ordering sequencer and datapath
//
// channel | handshake             | payload
// --------+-----------------------+-----------------------------------------------
// input   | start & !busy         | coordinate, last_value
// config  | cfg_valid & cfg_ready | cfg_index, cfg_data
// result  | result_strobe         | order_position, center_point, radius_squared,
//         |                       | radius, last_center
//
// A coordinate beat is accepted when start is high and busy is low. After the
// last beat, each center pass runs S_PT_START, S_RD/S_DIFF/S_SQ/S_ACC per
// dimension (shared coordinate-store read, one multiplier) and S_UPD per point.
// Non-final centers add a select and a serial square root; the last only a select.
// Reset clears control state only; the stores hold undefined data until loaded.
// Results cannot be stalled; busy and !cfg_ready stay high until the last strobe.
module greedy_k_center_ordering (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [gkc_pkg::COORD_BITS-1:0] coordinate,
    input  logic                               last_value,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [gkc_pkg::NP_BITS-1:0]        cfg_data,
    output logic                               result_strobe,
    output logic [gkc_pkg::PT_BITS-1:0]        order_position,
    output logic [gkc_pkg::PT_BITS-1:0]        center_point,
    output logic [gkc_pkg::RSQ_BITS-1:0]       radius_squared,
    output logic [gkc_pkg::ROOT_BITS-1:0]      radius,
    output logic                               last_center
);
    localparam int AB = gkc_pkg::ADDR_BITS;
    localparam int PB = gkc_pkg::PT_BITS;
    localparam int DB = gkc_pkg::DIST_BITS;

    gkc_pkg::state_t state_reg, state_next;
    gkc_pkg::fin_t   fin_reg, fin_next;

    logic [gkc_pkg::NP_BITS-1:0]  num_points_reg, n_sat;
    logic [gkc_pkg::ND_BITS-1:0]  num_dims_reg, d_sat;
    logic [AB-1:0]                load_count_reg, addr_i_reg, addr_c_reg;
    logic [gkc_pkg::MAX_POINTS-1:0] mark_reg;
    logic [PB-1:0]                i_reg, c_reg, rank_reg, best_reg;
    logic [gkc_pkg::DIM_BITS-1:0] k_reg;
    logic [DB-1:0]                acc_reg, bestd_reg, old_d, new_d;
    logic                         found_reg, first_reg;
    logic signed [gkc_pkg::DIFF_BITS-1:0] diff_reg;
    logic [gkc_pkg::SQ_BITS-1:0]  sq_reg;
    logic signed [gkc_pkg::SQ_BITS-1:0] prod;

    logic [gkc_pkg::COORD_BITS-1:0] ca, cb;
    logic        accept, coord_rd, dist_rd, dist_wr, last_dim, last_pt, take;
    logic        sq_start, sq_done;
    logic [gkc_pkg::ROOT_BITS-1:0] sq_root;

    assign accept    = start && !busy;
    assign cfg_ready = !busy;
    assign busy      = state_reg != gkc_pkg::S_IDLE || fin_reg != gkc_pkg::F_NONE;

    always_comb
    begin
        n_sat = num_points_reg;
        if (num_points_reg < 7'd2)
        begin
            n_sat = 7'd2;
        end
        else if (num_points_reg > 7'(gkc_pkg::MAX_POINTS))
        begin
            n_sat = 7'(gkc_pkg::MAX_POINTS);
        end
        d_sat = num_dims_reg;
        if (num_dims_reg < 4'd1)
        begin
            d_sat = 4'd1;
        end
        else if (num_dims_reg > 4'(gkc_pkg::MAX_DIMS))
        begin
            d_sat = 4'(gkc_pkg::MAX_DIMS);
        end
    end

    assign last_dim = {1'b0, k_reg} == d_sat - 4'd1;
    assign last_pt  = {1'b0, i_reg} == n_sat - 7'd1;
    assign prod     = diff_reg * diff_reg;
    assign new_d    = (first_reg || acc_reg < old_d) ? acc_reg : old_d;
    assign take     = !mark_reg[i_reg] && (!found_reg || new_d > bestd_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gkc_pkg::S_IDLE:
            begin
                if (accept && last_value)
                begin
                    state_next = gkc_pkg::S_PASS_INIT;
                end
            end
            gkc_pkg::S_PASS_INIT: state_next = gkc_pkg::S_PT_START;
            gkc_pkg::S_PT_START:  state_next = gkc_pkg::S_RD;
            gkc_pkg::S_RD:        state_next = gkc_pkg::S_DIFF;
            gkc_pkg::S_DIFF:      state_next = gkc_pkg::S_SQ;
            gkc_pkg::S_SQ:        state_next = gkc_pkg::S_ACC;
            gkc_pkg::S_ACC:       state_next = last_dim ? gkc_pkg::S_UPD : gkc_pkg::S_RD;
            gkc_pkg::S_UPD:       state_next = last_pt ? gkc_pkg::S_IDLE : gkc_pkg::S_PT_START;
            default:              state_next = gkc_pkg::S_IDLE;
        endcase
        if (fin_reg == gkc_pkg::F_SQRT && sq_done)
        begin
            state_next = gkc_pkg::S_PASS_INIT;
        end
    end

    always_comb
    begin
        fin_next = fin_reg;
        unique case (fin_reg)
            gkc_pkg::F_NONE:
            begin
                if (state_reg == gkc_pkg::S_UPD && last_pt)
                begin
                    fin_next = gkc_pkg::F_SEL;
                end
            end
            gkc_pkg::F_SEL:  fin_next = found_reg ? gkc_pkg::F_SQRT : gkc_pkg::F_NONE;
            gkc_pkg::F_SQRT:
            begin
                if (sq_done)
                begin
                    fin_next = gkc_pkg::F_NONE;
                end
            end
            default:         fin_next = gkc_pkg::F_NONE;
        endcase
    end

    always_comb
    begin
        coord_rd = state_reg == gkc_pkg::S_RD;
        dist_rd  = state_reg == gkc_pkg::S_PT_START;
        dist_wr  = state_reg == gkc_pkg::S_UPD;
        sq_start = fin_reg == gkc_pkg::F_SEL && found_reg;
    end

    gkc_coord_mem u_coord (
        .clk       (clk),
        .wr_en     (accept),
        .wr_addr   (load_count_reg),
        .wr_data   (coordinate),
        .rd_en     (coord_rd),
        .rd_addr_a (addr_i_reg),
        .rd_addr_b (addr_c_reg),
        .rd_data_a (ca),
        .rd_data_b (cb)
    );

    gkc_dist_mem u_dist (
        .clk     (clk),
        .wr_en   (dist_wr),
        .wr_addr (i_reg),
        .wr_data (new_d),
        .rd_en   (dist_rd),
        .rd_addr (i_reg),
        .rd_data (old_d)
    );

    gkc_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (bestd_reg[gkc_pkg::RSQ_BITS-1:0]),
        .done  (sq_done),
        .root  (sq_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gkc_pkg::S_IDLE;
            fin_reg        <= gkc_pkg::F_NONE;
            num_points_reg <= 7'(gkc_pkg::MAX_POINTS);
            num_dims_reg   <= 4'd2;
            load_count_reg <= '0;
            mark_reg       <= '0;
            result_strobe  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fin_reg       <= fin_next;
            result_strobe <= (fin_reg == gkc_pkg::F_SEL && !found_reg)
                          || (fin_reg == gkc_pkg::F_SQRT && sq_done);
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    gkc_pkg::CFG_NUM_POINTS: num_points_reg <= cfg_data;
                    gkc_pkg::CFG_NUM_DIMS:   num_dims_reg   <= cfg_data[gkc_pkg::ND_BITS-1:0];
                    default:                 num_points_reg <= num_points_reg;
                endcase
            end
            if (accept)
            begin
                load_count_reg <= last_value ? '0 : load_count_reg + 9'd1;
                if (last_value)
                begin
                    mark_reg <= '0;
                end
            end
            if (state_reg == gkc_pkg::S_PASS_INIT)
            begin
                mark_reg[c_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_value)
        begin
            c_reg     <= '0;
            rank_reg  <= '0;
            first_reg <= 1'b1;
        end
        unique case (state_reg)
            gkc_pkg::S_PASS_INIT:
            begin
                i_reg     <= '0;
                found_reg <= 1'b0;
                bestd_reg <= '0;
                best_reg  <= '0;
            end
            gkc_pkg::S_PT_START:
            begin
                addr_i_reg <= {3'b000, i_reg};
                addr_c_reg <= {3'b000, c_reg};
                k_reg      <= '0;
                acc_reg    <= '0;
            end
            gkc_pkg::S_DIFF:
            begin
                diff_reg <= $signed({ca[gkc_pkg::COORD_BITS-1], ca})
                          - $signed({cb[gkc_pkg::COORD_BITS-1], cb});
            end
            gkc_pkg::S_SQ:
            begin
                sq_reg <= prod;
            end
            gkc_pkg::S_ACC:
            begin
                acc_reg    <= acc_reg + {{(DB-gkc_pkg::SQ_BITS){1'b0}}, sq_reg};
                k_reg      <= k_reg + 3'd1;
                addr_i_reg <= addr_i_reg + {2'b00, n_sat};
                addr_c_reg <= addr_c_reg + {2'b00, n_sat};
            end
            gkc_pkg::S_UPD:
            begin
                i_reg <= i_reg + 6'd1;
                if (take)
                begin
                    best_reg  <= i_reg;
                    bestd_reg <= new_d;
                    found_reg <= 1'b1;
                end
            end
            default:
            begin
                diff_reg <= diff_reg;
            end
        endcase
        if (fin_reg == gkc_pkg::F_SEL && !found_reg)
        begin
            order_position <= rank_reg;
            center_point   <= c_reg;
            radius_squared <= '0;
            radius         <= '0;
            last_center    <= 1'b1;
        end
        if (fin_reg == gkc_pkg::F_SQRT && sq_done)
        begin
            order_position <= rank_reg;
            center_point   <= c_reg;
            radius_squared <= bestd_reg[gkc_pkg::RSQ_BITS-1:0];
            radius         <= sq_root;
            last_center    <= 1'b0;
            c_reg          <= best_reg;
            rank_reg       <= rank_reg + 6'd1;
            first_reg      <= 1'b0;
        end
    end

    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |=> !result_strobe)
        else $error("back-to-back result strobes");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_value) |=> busy)
        else $error("run did not start on last beat");

    a_sqrt_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_reg == gkc_pkg::F_SQRT) |-> (state_reg == gkc_pkg::S_IDLE))
        else $error("pass running while root pending");
endmodule
